// ===== sv/sbcd_pkg.sv =====
// Shared types, constants and helpers for the signed binary to BCD converter.
// No dependencies; every other file of the block imports this package.
package sbcd_pkg;

   // Field widths
   localparam int OPCODE_W = 2;
   localparam int COUNT_W  = 4;
   localparam int VALUE_W  = 64;
   localparam int BYTES    = VALUE_W / 8;

   // Double-dabble geometry: 56 magnitude bits cover anything below 10^16
   localparam int BIN_W         = 56;
   localparam int STAGE_BITS    = 8;
   localparam int DABBLE_STAGES = BIN_W / STAGE_BITS;
   localparam int DIGITS        = VALUE_W / 4;

   // Range limits
   localparam logic [7:0]  LIM_BYTE  = 8'd99;
   localparam logic [15:0] LIM_WORD  = 16'd9999;
   localparam logic [31:0] LIM_DWORD = 32'd99999999;
   localparam logic [63:0] LIM_QWORD = 64'd10000000000000000;
   localparam logic [7:0]  SIGN_BIT  = 8'h80;

   // Conversion modes; code three has no meaning and fails
   typedef enum logic [OPCODE_W-1:0] {
      OP_BYTEWISE = 2'd0,
      OP_COMBINED = 2'd1,
      OP_METER    = 2'd2
   } opcode_type;

   typedef struct packed {
      logic               good;
      logic               neg;
      logic               meter;
      logic               bytewise;
      logic [COUNT_W-1:0] count;
   } ctrl_type;

   // Word travelling through the pipeline
   typedef struct packed {
      ctrl_type           ctrl;
      logic [BIN_W-1:0]   bin;
      logic [VALUE_W-1:0] bcd;
      logic [VALUE_W-1:0] byte_res;
   } stage_type;

   // Two BCD digits of a value up to 99 (seven shift-add-3 steps)
   function automatic logic [7:0] byte_to_bcd(input logic [6:0] b);
      logic [7:0] d;
      d = 8'd0;
      for (int k = 6; k >= 0; k--) begin
         if (d[3:0] >= 4'd5) d[3:0] = d[3:0] + 4'd3;
         if (d[7:4] >= 4'd5) d[7:4] = d[7:4] + 4'd3;
         d = {d[6:0], b[k]};
      end
      return d;
   endfunction

endpackage

// ===== sv/sbcd_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on sbcd_pkg for field widths.
interface sbcd_req_if;
   import sbcd_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [COUNT_W-1:0]  byte_count;
   logic [VALUE_W-1:0]  value_in;

   modport source (output valid, output opcode, output byte_count, output value_in,
                   input ready);
   modport sink   (input valid, input opcode, input byte_count, input value_in,
                   output ready);
endinterface

interface sbcd_rsp_if;
   import sbcd_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] bcd_out;
   logic               ok;

   modport source (output valid, output bcd_out, output ok, input ready);
   modport sink   (input valid, input bcd_out, input ok, output ready);
endinterface

// ===== sv/sbcd_front.sv =====
// Input stage: mode decode, magnitude, range checks and bytewise conversion.
// Depends on sbcd_pkg and sbcd_req_if.
module sbcd_front (
   input  logic                clock,
   input  logic                reset,
   sbcd_req_if.sink            req_chan,
   output logic                out_valid,
   input  logic                out_ready,
   output sbcd_pkg::stage_type out_data
);
   import sbcd_pkg::*;

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;

   logic [31:0]        mag32;
   logic [VALUE_W-1:0] mag64;
   logic [VALUE_W-1:0] bytes_bcd;
   logic               bytes_ok;
   opcode_type         op;

   assign req_chan.ready = !valid_ff || out_ready;
   assign op = opcode_type'(req_chan.opcode);

   // Magnitudes of the short and long signed forms
   assign mag32 = req_chan.value_in[31] ? (32'd0 - req_chan.value_in[31:0])
                                        : req_chan.value_in[31:0];
   assign mag64 = req_chan.value_in[63] ? (64'd0 - req_chan.value_in)
                                        : req_chan.value_in;

   // Per-byte conversion, bytes at and above the length are not checked
   always_comb begin
      bytes_ok  = 1'b1;
      bytes_bcd = '0;
      for (int i = 0; i < BYTES; i++) begin
         bytes_bcd[8*i +: 8] = byte_to_bcd(req_chan.value_in[8*i +: 7]);
         if (req_chan.value_in[8*i +: 8] > LIM_BYTE && COUNT_W'(i) < req_chan.byte_count)
            bytes_ok = 1'b0;
      end
   end

   // Mode decode
   always_comb begin
      data_in               = '0;
      data_in.ctrl.count    = req_chan.byte_count;
      data_in.byte_res      = bytes_bcd;
      unique case (op)
         OP_BYTEWISE: begin
            data_in.ctrl.bytewise = 1'b1;
            data_in.ctrl.good     = bytes_ok;
         end
         OP_COMBINED: begin
            case (req_chan.byte_count)
               4'd1: begin
                  data_in.bin       = BIN_W'(req_chan.value_in[7:0]);
                  data_in.ctrl.good = req_chan.value_in[7:0] <= LIM_BYTE;
               end
               4'd2: begin
                  data_in.bin       = BIN_W'(req_chan.value_in[15:0]);
                  data_in.ctrl.good = req_chan.value_in[15:0] <= LIM_WORD;
               end
               4'd4: begin
                  data_in.bin       = BIN_W'(req_chan.value_in[31:0]);
                  data_in.ctrl.good = req_chan.value_in[31:0] <= LIM_DWORD;
               end
               default: data_in.ctrl.good = 1'b0;
            endcase
         end
         OP_METER: begin
            data_in.ctrl.meter = 1'b1;
            if (req_chan.byte_count == 4'd0 || req_chan.byte_count > 4'd8) begin
               data_in.ctrl.good = 1'b0;
            end else if (req_chan.byte_count <= 4'd4) begin
               data_in.ctrl.neg  = req_chan.value_in[31];
               data_in.bin       = BIN_W'(mag32);
               data_in.ctrl.good = mag32 <= LIM_DWORD;
            end else begin
               data_in.ctrl.neg  = req_chan.value_in[63];
               data_in.bin       = mag64[BIN_W-1:0];
               data_in.ctrl.good = mag64 < LIM_QWORD;
            end
         end
         default: data_in.ctrl.good = 1'b0;
      endcase
      // Lengths above eight fail in every mode
      if (req_chan.byte_count > 4'd8) data_in.ctrl.good = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/sbcd_dabble_stage.sv =====
// One pipeline stage of the shift-add-3 converter: eight magnitude bits a stage.
// Depends on sbcd_pkg.
module sbcd_dabble_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sbcd_pkg::stage_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sbcd_pkg::stage_type out_data
);
   import sbcd_pkg::*;

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // Eight correct-then-shift steps, magnitude MSB first
   always_comb begin
      logic [VALUE_W-1:0] work_bcd;
      logic [BIN_W-1:0]   work_bin;
      work_bcd = in_data.bcd;
      work_bin = in_data.bin;
      for (int s = 0; s < STAGE_BITS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (work_bcd[4*d +: 4] >= 4'd5) work_bcd[4*d +: 4] = work_bcd[4*d +: 4] + 4'd3;
         end
         work_bcd = {work_bcd[VALUE_W-2:0], work_bin[BIN_W-1]};
         work_bin = {work_bin[BIN_W-2:0], 1'b0};
      end
      data_in     = in_data;
      data_in.bcd = work_bcd;
      data_in.bin = work_bin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/sbcd_back.sv =====
// Output stage: result select, length mask, sign bit and failure zeroing.
// Depends on sbcd_pkg and sbcd_rsp_if.
module sbcd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sbcd_pkg::stage_type in_data,
   sbcd_rsp_if.source          rsp_chan
);
   import sbcd_pkg::*;

   logic               valid_ff;
   logic [VALUE_W-1:0] bcd_ff;
   logic               ok_ff;
   logic [VALUE_W-1:0] bcd_in;

   assign in_ready = !valid_ff || rsp_chan.ready;

   // Keep the low count bytes, mark the top one when a meter value is negative
   always_comb begin
      logic [VALUE_W-1:0] raw;
      raw    = in_data.ctrl.bytewise ? in_data.byte_res : in_data.bcd;
      bcd_in = '0;
      for (int i = 0; i < BYTES; i++) begin
         if (COUNT_W'(i) < in_data.ctrl.count) bcd_in[8*i +: 8] = raw[8*i +: 8];
         if (in_data.ctrl.meter && in_data.ctrl.neg && in_data.ctrl.count == COUNT_W'(i + 1))
            bcd_in[8*i +: 8] = bcd_in[8*i +: 8] | SIGN_BIT;
      end
      if (!in_data.ctrl.good) bcd_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         bcd_ff <= bcd_in;
         ok_ff  <= in_data.ctrl.good;
      end
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.bcd_out = bcd_ff;
   assign rsp_chan.ok      = ok_ff;

endmodule

// ===== sv/signed_binary_to_bcd_converter_unit.sv =====
// Signed binary to packed BCD converter, top level.
// Pipeline: decode stage, seven shift-add-3 stages of eight bits each, output register.
// Throughput one word per cycle; each stage holds its word only while the next one stalls.
// Synchronous reset clears the stage valid bits; payload registers are not reset.
// Depends on sbcd_pkg, sbcd_if, sbcd_front, sbcd_dabble_stage and sbcd_back.
module signed_binary_to_bcd_converter_unit (
   input  logic       clock,
   input  logic       reset,
   sbcd_req_if.sink   req_chan,
   sbcd_rsp_if.source rsp_chan
);
   import sbcd_pkg::*;

   logic      link_valid [0:DABBLE_STAGES];
   logic      link_ready [0:DABBLE_STAGES];
   stage_type link_data  [0:DABBLE_STAGES];

   // Decode and range check
   sbcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // Conversion pipeline
   for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
      sbcd_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_data   (link_data[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_data  (link_data[g+1])
      );
   end

   // Formatting and output register
   sbcd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (link_valid[DABBLE_STAGES]),
      .in_ready (link_ready[DABBLE_STAGES]),
      .in_data  (link_data[DABBLE_STAGES]),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== test/tb_signed_binary_to_bcd_converter_unit.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the signed binary to packed BCD converter: a directed table, then
// random words under three idle patterns, checked against an in-bench predictor.
// Depends on sbcd_pkg, sbcd_if and signed_binary_to_bcd_converter_unit.
module tb_signed_binary_to_bcd_converter_unit;
   import sbcd_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         LONG_STALL = 200;
   localparam int         IDLE_LIMIT = 3000;
   localparam int         DRAIN_TAIL = 20;
   localparam int         RAND_WORDS = 550;

   typedef struct packed {
      logic [63:0] bcd;
      logic        ok;
   } bcd_word_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  n;
      logic [63:0] v;
   } req_word_type;

   typedef struct {
      req_word_type word;
      bit           typed;
      bcd_word_type result;
   } dir_row_type;

   logic clock;
   logic reset;

   sbcd_req_if req_chan ();
   sbcd_rsp_if rsp_chan ();

   signed_binary_to_bcd_converter_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bcd_word_type pending_bcd_q[$];
   int           fail_count    = 0;
   int           idle_cycles   = 0;
   int           send_idle_pct = 0;
   int           rcv_idle_pct  = 0;
   int           stalls_asked  = 0;
   int           stalls_done   = 0;
   bit           drive_typed   = 0;
   bcd_word_type drive_result  = '0;

   // Directed words: extremes, every mode, bad lengths, sign handling
   dir_row_type directed_rows [25] = '{
      '{'{OP_BYTEWISE, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF}, 1, '{64'h0, 1'b1}},
      '{'{OP_BYTEWISE, 4'd8,  64'h6363_6363_6363_6363}, 1, '{64'h9999_9999_9999_9999, 1'b1}},
      '{'{OP_BYTEWISE, 4'd8,  64'h0000_0000_0000_0064}, 1, '{64'h0, 1'b0}},
      '{'{OP_BYTEWISE, 4'd3,  64'hFFFF_FFFF_FF00_0102}, 0, '{64'h0, 1'b0}},
      '{'{OP_BYTEWISE, 4'd7,  64'h9A00_0000_0000_0000}, 0, '{64'h0, 1'b0}},
      '{'{OP_COMBINED, 4'd1,  64'h0000_0000_0000_0063}, 1, '{64'h99, 1'b1}},
      '{'{OP_COMBINED, 4'd1,  64'h0000_0000_0000_0064}, 1, '{64'h0, 1'b0}},
      '{'{OP_COMBINED, 4'd2,  64'h0000_0000_0000_270F}, 1, '{64'h9999, 1'b1}},
      '{'{OP_COMBINED, 4'd2,  64'h0000_0000_0000_2710}, 1, '{64'h0, 1'b0}},
      '{'{OP_COMBINED, 4'd4,  64'hFFFF_FFFF_05F5_E0FF}, 1, '{64'h9999_9999, 1'b1}},
      '{'{OP_COMBINED, 4'd4,  64'h0000_0000_05F5_E100}, 1, '{64'h0, 1'b0}},
      '{'{OP_COMBINED, 4'd3,  64'h0000_0000_0000_0000}, 1, '{64'h0, 1'b0}},
      '{'{OP_COMBINED, 4'd8,  64'h0000_0000_0000_0000}, 1, '{64'h0, 1'b0}},
      '{'{OP_COMBINED, 4'd0,  64'h0000_0000_0000_0000}, 1, '{64'h0, 1'b0}},
      '{'{OP_METER,    4'd0,  64'h0000_0000_0000_0001}, 1, '{64'h0, 1'b0}},
      '{'{OP_METER,    4'd4,  64'hFFFF_FFFF_FA0A_1F01}, 0, '{64'h0, 1'b0}},
      '{'{OP_METER,    4'd1,  64'h0000_0000_FFFF_FFFF}, 0, '{64'h0, 1'b0}},
      '{'{OP_METER,    4'd4,  64'h0000_0000_8000_0000}, 1, '{64'h0, 1'b0}},
      '{'{OP_METER,    4'd4,  64'h0000_0000_05F5_E100}, 1, '{64'h0, 1'b0}},
      '{'{OP_METER,    4'd8,  64'h0023_86F2_6FC0_FFFF}, 1, '{64'h9999_9999_9999_9999, 1'b1}},
      '{'{OP_METER,    4'd8,  64'h0023_86F2_6FC1_0000}, 1, '{64'h0, 1'b0}},
      '{'{OP_METER,    4'd8,  64'h8000_0000_0000_0000}, 1, '{64'h0, 1'b0}},
      '{'{OP_METER,    4'd5,  64'hFFFF_FFFF_FFFF_FFFF}, 0, '{64'h0, 1'b0}},
      '{'{OP_UNUSED,   4'd1,  64'h0000_0000_0000_0000}, 1, '{64'h0, 1'b0}},
      '{'{OP_METER,    4'd15, 64'h0000_0000_0000_0001}, 1, '{64'h0, 1'b0}}
   };

   // Decimal digits of v, low digit in the low nibble
   function automatic logic [63:0] pack_digits(logic [63:0] v, int unsigned ndig);
      logic [63:0] r;
      r = '0;
      for (int unsigned i = 0; i < ndig; i++) begin
         r[4*i +: 4] = 4'(v % 64'd10);
         v = v / 64'd10;
      end
      return r;
   endfunction

   // Expected packed BCD and ok flag for one request word
   function automatic bcd_word_type predict_bcd(req_word_type w);
      bcd_word_type r;
      logic [63:0]  keep;
      logic [63:0]  low;
      logic [63:0]  mag;
      logic [31:0]  mag32;
      logic         neg;
      r    = '0;
      neg  = 1'b0;
      keep = (w.n >= 4'd8) ? '1 : ((64'd1 << (8 * w.n)) - 64'd1);
      low  = w.v & keep;
      if (w.n <= 4'd8) begin
         case (w.op)
            OP_BYTEWISE: begin
               r.ok = 1'b1;
               for (int i = 0; i < 8; i++)
                  if (i < w.n) begin
                     if (w.v[8*i +: 8] > LIM_BYTE) r.ok = 1'b0;
                     else r.bcd[8*i +: 8] = 8'(pack_digits({56'd0, w.v[8*i +: 8]}, 2));
                  end
            end
            OP_COMBINED: begin
               if ((w.n == 4'd1 && low <= 64'(LIM_BYTE)) || (w.n == 4'd2 && low <= 64'(LIM_WORD))
                   || (w.n == 4'd4 && low <= 64'(LIM_DWORD))) begin
                  r.bcd = pack_digits(low, 8);
                  r.ok  = 1'b1;
               end
            end
            OP_METER: begin
               if (w.n >= 4'd1 && w.n <= 4'd4) begin
                  neg   = w.v[31];
                  mag32 = neg ? -w.v[31:0] : w.v[31:0];
                  if (mag32 <= LIM_DWORD) begin
                     r.bcd = pack_digits({32'd0, mag32}, 8);
                     r.ok  = 1'b1;
                  end
               end else if (w.n >= 4'd5) begin
                  neg = w.v[63];
                  mag = neg ? -w.v : w.v;
                  if (mag < LIM_QWORD) begin
                     r.bcd = pack_digits(mag, 16);
                     r.ok  = 1'b1;
                  end
               end
               // sign lands in the top kept byte, even over a digit
               if (r.ok) begin
                  r.bcd = r.bcd & keep;
                  if (neg) r.bcd[8 * (w.n - 1) + 7] = 1'b1;
               end
            end
            default: ;
         endcase
      end
      r.bcd = r.ok ? (r.bcd & keep) : '0;
      return r;
   endfunction

   // Mostly well-formed words with random content; the rest out of range, bad length or unused mode
   function automatic req_word_type random_word();
      req_word_type w;
      logic [63:0]  mag;
      int           roll;
      int           pick;
      roll = $urandom_range(99);
      w.v  = {$urandom, $urandom};
      if (roll < 30) begin
         w.op = OP_BYTEWISE;
         w.n  = 4'($urandom_range(8));
         for (int i = 0; i < 8; i++) w.v[8*i +: 8] = 8'($urandom_range(99));
         if ($urandom_range(99) < 20) w.v[8 * $urandom_range(7) +: 8] = 8'($urandom);
         if ($urandom_range(99) < 30) w.v[63:32] = $urandom;
      end else if (roll < 60) begin
         w.op = OP_COMBINED;
         pick = $urandom_range(99);
         if (pick < 85) w.n = (pick < 28) ? 4'd1 : (pick < 56) ? 4'd2 : 4'd4;
         else w.n = 4'($urandom_range(8));
         if ($urandom_range(99) < 80) begin
            case (w.n)
               4'd1:    w.v[7:0]  = 8'($urandom_range(LIM_BYTE));
               4'd2:    w.v[15:0] = 16'($urandom_range(LIM_WORD));
               default: w.v[31:0] = $urandom_range(LIM_DWORD);
            endcase
            if ($urandom_range(1) == 0) w.v[63:32] = '0;
            if (w.n != 4'd4 && $urandom_range(1) == 0) w.v[31:16] = '0;
         end
      end else if (roll < 92) begin
         w.op = OP_METER;
         w.n  = 4'($urandom_range(1, 8));
         pick = $urandom_range(99);
         if (w.n <= 4'd4) begin
            if (pick < 75) mag = 64'($urandom_range(LIM_DWORD));
            else if (pick < 90) mag = 64'(LIM_DWORD) - 64'($urandom_range(3)) + 64'd1;
            else mag = 64'($urandom);
            if ($urandom_range(1) == 0) w.v[31:0] = mag[31:0];
            else w.v[31:0] = -mag[31:0];
         end else begin
            if (pick < 75)
               mag = 64'($urandom_range(LIM_DWORD)) * 64'd100000000
                     + 64'($urandom_range(LIM_DWORD));
            else if (pick < 90) mag = LIM_QWORD - 64'($urandom_range(3)) + 64'd1;
            else mag = {$urandom, $urandom};
            w.v = ($urandom_range(1) == 0) ? mag : -mag;
         end
      end else if (roll < 96) begin
         w.op = OP_UNUSED;
         w.n  = 4'($urandom);
      end else begin
         w.op = 2'($urandom_range(3));
         w.n  = 4'($urandom_range(9, 15));
      end
      return w;
   endfunction

   // Offer one word from a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input req_word_type w, input bit typed, input bcd_word_type result);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid      <= 1'b0;
         req_chan.opcode     <= 2'($urandom);
         req_chan.byte_count <= 4'($urandom);
         req_chan.value_in   <= {$urandom, $urandom};
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= w.op;
      req_chan.byte_count <= w.n;
      req_chan.value_in   <= w.v;
      drive_typed  = typed;
      drive_result = result;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Stop offering until every expected word has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_bcd_q.size() != 0);
   endtask

   task automatic random_phase(input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      rcv_idle_pct  = r_pct;
      for (int k = 0; k < RAND_WORDS; k++) begin
         if (k == 150) stalls_asked++;
         if (k == 350) drain();
         send_word(random_word(), 0, '0);
      end
      drain();
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: random back-pressure, plus long hold-offs on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stalls_done != stalls_asked) begin
            stalls_done++;
            repeat (LONG_STALL) begin
               rsp_chan.ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // Scoreboard and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_bcd_q.size() == 0) begin
               $error("unexpected word: bcd_out %h ok %b", rsp_chan.bcd_out, rsp_chan.ok);
               fail_count++;
            end else begin
               if (rsp_chan.bcd_out !== pending_bcd_q[0].bcd) begin
                  $error("bcd_out: expected %h, got %h", pending_bcd_q[0].bcd, rsp_chan.bcd_out);
                  fail_count++;
               end
               if (rsp_chan.ok !== pending_bcd_q[0].ok) begin
                  $error("ok: expected %b, got %b", pending_bcd_q[0].ok, rsp_chan.ok);
                  fail_count++;
               end
               void'(pending_bcd_q.pop_front());
            end
         end
         if (req_chan.valid && req_chan.ready)
            pending_bcd_q.push_back(drive_typed ? drive_result
               : predict_bcd('{req_chan.opcode, req_chan.byte_count, req_chan.value_in}));
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Stimulus
   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.opcode     = '0;
      req_chan.byte_count = '0;
      req_chan.value_in   = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      rcv_idle_pct  = 54;
      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);
      drain();

      random_phase(20, 54);
      random_phase(54, 20);
      random_phase(0, 0);

      repeat (DRAIN_TAIL) @(negedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
